FILE: rtl/textured_wall_column_span_macros.svh
// Assertion helpers shared by the checker
`ifndef TEXTURED_WALL_COLUMN_SPAN_MACROS_SVH
`define TEXTURED_WALL_COLUMN_SPAN_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define TWCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define TWCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/twcs_pkg.sv
`timescale 1ns / 1ps
package twcs_pkg;

	localparam int FRAC_BITS         = 16;
	localparam int MAX_SCREEN_HEIGHT = 2048;
	localparam int POS_W             = 28;
	localparam int DIV_STEPS         = POS_W;
	localparam int CNT_W             = $clog2(DIV_STEPS);

	// Item kinds
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// Configuration register indexes
	localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd0;
	localparam logic [2:0] REG_TEX_SOUTH     = 3'd1;
	localparam logic [2:0] REG_TEX_EAST      = 3'd2;
	localparam logic [2:0] REG_TEX_NORTH     = 3'd3;
	localparam logic [2:0] REG_TEX_WEST      = 3'd4;

	// Hit sides
	localparam logic [1:0] SIDE_SOUTH = 2'd0;
	localparam logic [1:0] SIDE_EAST  = 2'd1;
	localparam logic [1:0] SIDE_NORTH = 2'd2;
	localparam logic [1:0] SIDE_WEST  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_H,
		ST_LINH,
		ST_DIV_T,
		ST_SETUP
	} state_t;

	typedef struct packed {
		logic ready;
		logic div_step;
		logic load_t;
		logic setup;
	} ctrl_cmd_t;

	typedef struct packed {
		logic req_valid;
		logic req_start;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: rtl/twcs_req_if.sv
`timescale 1ns / 1ps
interface twcs_req_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [11:0]        column;
	logic [25:0]        wall_dist;
	logic [1:0]         hit_side;
	logic [25:0]        pos_x;
	logic [25:0]        pos_y;
	logic signed [17:0] ray_x;
	logic signed [17:0] ray_y;

	modport source (output valid, kind, column, wall_dist, hit_side, pos_x, pos_y,
		ray_x, ray_y, input ready);
	modport sink (input valid, kind, column, wall_dist, hit_side, pos_x, pos_y,
		ray_x, ray_y, output ready);
endinterface

FILE: rtl/twcs_pix_if.sv
`timescale 1ns / 1ps
interface twcs_pix_if;
	logic        valid;
	logic        ready;
	logic [11:0] out_column;
	logic [10:0] out_row;
	logic [1:0]  texture_select;
	logic [11:0] texel_col;
	logic [11:0] texel_row;
	logic        last;

	modport source (output valid, out_column, out_row, texture_select, texel_col,
		texel_row, last, input ready);
	modport sink (input valid, out_column, out_row, texture_select, texel_col,
		texel_row, last, output ready);
endinterface

FILE: rtl/twcs_ctrl.sv
`timescale 1ns / 1ps
module twcs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  twcs_pkg::dp_stat_t  stat,
	output twcs_pkg::ctrl_cmd_t cmd
);
	import twcs_pkg::*;

	state_t           state_q, state_nx;
	logic [CNT_W-1:0] cnt_q;
	logic             cnt_last;

	assign cnt_last = (cnt_q == CNT_W'(DIV_STEPS - 1));

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:  if (stat.req_valid && stat.out_free && stat.req_start) state_nx = ST_DIV_H;
			ST_DIV_H: if (cnt_last) state_nx = ST_LINH;
			ST_LINH:  state_nx = ST_DIV_T;
			ST_DIV_T: if (cnt_last) state_nx = ST_SETUP;
			ST_SETUP: state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:  cmd.ready = stat.out_free;
			ST_DIV_H: cmd.div_step = 1'b1;
			ST_LINH:  cmd.load_t = 1'b1;
			ST_DIV_T: cmd.div_step = 1'b1;
			ST_SETUP: cmd.setup = 1'b1;
			default:  cmd = '0;
		endcase
	end

	// State and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_nx != state_q)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
		end
	end
endmodule

FILE: rtl/twcs_dp.sv
`timescale 1ns / 1ps
module twcs_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [23:0]         cfg_data,
	input  twcs_pkg::ctrl_cmd_t cmd,
	output twcs_pkg::dp_stat_t  stat,
	twcs_req_if.sink            req,
	twcs_pix_if.source          pix
);
	import twcs_pkg::*;

	// Configuration
	logic [11:0] screen_height_q;
	logic [23:0] tex_size_q [4];

	// Captured start item
	logic [11:0]        h_q;
	logic [25:0]        dist_q;
	logic [15:0]        pos_q;
	logic signed [17:0] ray_q;
	logic               mirror_q;
	logic [15:0]        wallx_q;
	logic [POS_W-1:0]   linh_q;

	// Shared restoring divider
	logic [POS_W-1:0] rem_q, quo_q, den_q;
	logic [POS_W:0]   rem_sh;
	logic             fits;

	// Span state
	logic             span_active_q;
	logic [10:0]      current_row_q, end_row_q;
	logic [POS_W-1:0] tex_pos_q, tex_step_q;
	logic [11:0]      held_texel_col_q, held_column_q;
	logic [1:0]       held_side_q;

	// Output register
	logic        out_valid_q;
	logic [11:0] out_column_q, texel_col_q, texel_row_q;
	logic [10:0] out_row_q;
	logic [1:0]  tsel_q;
	logic        last_q;

	logic        accept, start_acc, tick_emit;
	logic [11:0] h_in;
	logic        xy_in;
	logic [11:0] tw, th;
	logic signed [44:0] prod;
	logic [POS_W-1:0] linh_now, step_now, end_full, half_l;
	logic [10:0] half_h;
	logic [POS_W-1:0] first_full, offset;
	logic [2*POS_W-1:0] pos_prod;
	logic [27:0] col_prod;
	logic [11:0] col_raw, col_fin;
	logic        span_ok;
	logic [11:0] trow_raw, trow;
	logic        last_now;

	assign accept    = req.valid && cmd.ready;
	assign start_acc = accept && (req.kind == KIND_START);
	assign tick_emit = accept && (req.kind == KIND_TICK) && span_active_q;
	assign req.ready = cmd.ready;

	assign stat.req_valid = req.valid;
	assign stat.req_start = (req.kind == KIND_START);
	assign stat.out_free  = !out_valid_q || pix.ready;

	assign h_in  = (screen_height_q > 12'(MAX_SCREEN_HEIGHT)) ? 12'(MAX_SCREEN_HEIGHT)
		: screen_height_q;
	assign xy_in = (req.hit_side == SIDE_SOUTH) || (req.hit_side == SIDE_NORTH);

	// Texture size of the held side
	assign tw = tex_size_q[held_side_q][11:0];
	assign th = tex_size_q[held_side_q][23:12];

	// Divider step
	assign rem_sh = {rem_q, quo_q[POS_W-1]};
	assign fits   = (rem_sh >= {1'b0, den_q});

	// Hit fraction product
	assign prod = $signed({1'b0, dist_q}) * ray_q;

	// Row range and texture setup
	assign linh_now   = (dist_q == '0) ? POS_W'(h_q) : quo_q;
	assign step_now   = (linh_q == '0) ? '0 : quo_q;
	assign half_l     = linh_q >> 1;
	assign half_h     = h_q[11:1];
	assign first_full = (half_l > POS_W'(half_h)) ? '0 : POS_W'(half_h) - half_l;
	assign offset     = (half_l > POS_W'(half_h)) ? half_l - POS_W'(half_h) : '0;
	assign end_full   = (h_q == '0) ? '0
		: ((POS_W'(half_h) + half_l >= POS_W'(h_q)) ? POS_W'(h_q) - 1'b1
		: POS_W'(half_h) + half_l);
	assign pos_prod   = offset * step_now;
	assign span_ok    = (h_q != '0) && (linh_q != '0) && (end_full > first_full);

	// Texture column
	assign col_prod = wallx_q * tw;
	assign col_raw  = col_prod[27:16];
	assign col_fin  = (tw == '0) ? '0 : (mirror_q ? tw - col_raw - 1'b1 : col_raw);

	// Texel row clamp
	assign trow_raw = tex_pos_q[POS_W-1:FRAC_BITS];
	assign trow     = (th == '0) ? '0 : ((trow_raw > th - 1'b1) ? th - 1'b1 : trow_raw);
	assign last_now = ({1'b0, current_row_q} + 12'd1 >= {1'b0, end_row_q});

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_height_q <= 12'd480;
			for (int i = 0; i < 4; i++)
				tex_size_q[i] <= 24'h040040;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[11:0];
				REG_TEX_SOUTH:     tex_size_q[0] <= cfg_data;
				REG_TEX_EAST:      tex_size_q[1] <= cfg_data;
				REG_TEX_NORTH:     tex_size_q[2] <= cfg_data;
				REG_TEX_WEST:      tex_size_q[3] <= cfg_data;
				default:           ;
			endcase
		end
	end

	// Start capture, divider and setup datapath
	always_ff @(posedge clk) begin
		wallx_q <= pos_q + prod[31:16];
		if (start_acc) begin
			h_q      <= h_in;
			dist_q   <= req.wall_dist;
			pos_q    <= xy_in ? req.pos_y[15:0] : req.pos_x[15:0];
			ray_q    <= xy_in ? req.ray_y : req.ray_x;
			mirror_q <= (xy_in && !req.ray_x[17] && (req.ray_x != '0))
				|| ((req.hit_side == SIDE_EAST) && req.ray_y[17]);
			rem_q    <= '0;
			quo_q    <= {h_in, 16'd0};
			den_q    <= POS_W'(req.wall_dist);
		end else if (cmd.div_step) begin
			rem_q <= fits ? POS_W'(rem_sh - {1'b0, den_q}) : rem_sh[POS_W-1:0];
			quo_q <= {quo_q[POS_W-2:0], fits};
		end else if (cmd.load_t) begin
			linh_q <= linh_now;
			rem_q  <= '0;
			quo_q  <= {th, 16'd0};
			den_q  <= linh_now;
		end
	end

	// Span state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_active_q    <= 1'b0;
			current_row_q    <= '0;
			end_row_q        <= '0;
			tex_pos_q        <= '0;
			tex_step_q       <= '0;
			held_texel_col_q <= '0;
			held_column_q    <= '0;
			held_side_q      <= '0;
		end else if (start_acc) begin
			span_active_q <= 1'b0;
			held_column_q <= req.column;
			held_side_q   <= req.hit_side;
		end else if (cmd.setup) begin
			span_active_q    <= span_ok;
			current_row_q    <= first_full[10:0];
			end_row_q        <= end_full[10:0];
			tex_step_q       <= step_now;
			tex_pos_q        <= pos_prod[POS_W-1:0];
			held_texel_col_q <= col_fin;
		end else if (tick_emit) begin
			tex_pos_q     <= tex_pos_q + tex_step_q;
			current_row_q <= current_row_q + 1'b1;
			if (last_now)
				span_active_q <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (tick_emit)
			out_valid_q <= 1'b1;
		else if (pix.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (tick_emit) begin
			out_column_q <= held_column_q;
			out_row_q    <= current_row_q;
			tsel_q       <= held_side_q;
			texel_col_q  <= held_texel_col_q;
			texel_row_q  <= trow;
			last_q       <= last_now;
		end
	end

	assign pix.valid          = out_valid_q;
	assign pix.out_column     = out_column_q;
	assign pix.out_row        = out_row_q;
	assign pix.texture_select = tsel_q;
	assign pix.texel_col      = texel_col_q;
	assign pix.texel_row      = texel_row_q;
	assign pix.last           = last_q;
endmodule

FILE: rtl/textured_wall_column_span.sv
`timescale 1ns / 1ps
// Textured wall column span. A start transaction sets up one screen column: it is
// taken, then the block runs two divisions on one shared bit-serial divider (wall
// height, a load state, texture step) and a setup state before taking the next one.
// Ticks then go one per cycle while the output is not stalled, each giving one wall
// pixel from an output register; a tick with no active span gives nothing. The last
// pixel of a span carries last. Configuration is written through cfg_we, cfg_index
// and cfg_data; the user must do so only while idle, the block does not enforce it.
module textured_wall_column_span (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	twcs_req_if.sink    req,
	twcs_pix_if.source  pix
);
	import twcs_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	twcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	twcs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.req       (req),
		.pix       (pix)
	);
endmodule

FILE: rtl/twcs_chk.sv
`timescale 1ns / 1ps
`include "textured_wall_column_span_macros.svh"
module twcs_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_kind,
	input logic        pix_valid,
	input logic        pix_ready,
	input logic [10:0] pix_row,
	input logic [11:0] pix_texel_row
);
	import twcs_pkg::*;

	logic start_acc;
	assign start_acc = req_valid && req_ready && (req_kind == KIND_START);

	// A waiting pixel is not withdrawn
	`TWCS_ASSERT_NEXT(a_pix_hold, pix_valid && !pix_ready, pix_valid, "pixel dropped")
	// A waiting pixel does not change
	`TWCS_ASSERT_NEXT(a_pix_stable, pix_valid && !pix_ready,
		$stable(pix_row) && $stable(pix_texel_row), "pixel changed while stalled")
	// Setup keeps the input closed while dividing
	`TWCS_ASSERT_NEXT(a_start_busy, start_acc, !req_ready, "input open after start")
	`TWCS_ASSERT_NOW(a_start_busy2, $past(start_acc, 2), !req_ready, "input open in divide")
endmodule

bind textured_wall_column_span twcs_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_kind      (req.kind),
	.pix_valid     (pix.valid),
	.pix_ready     (pix.ready),
	.pix_row       (pix.out_row),
	.pix_texel_row (pix.texel_row)
);

FILE: test/textured_wall_column_span_tb.sv
`timescale 1ns / 1ps
module textured_wall_column_span_tb;
	import twcs_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETUP_DRAIN = 80;
	localparam int ITEM_GOAL   = 1950;

	typedef struct {
		logic               kind;
		logic [11:0]        column;
		logic [25:0]        wdist;
		logic [1:0]         side;
		logic [25:0]        px;
		logic [25:0]        py;
		logic signed [17:0] rx;
		logic signed [17:0] ry;
	} ray_item_t;

	typedef struct {
		logic [11:0] column;
		logic [10:0] row;
		logic [1:0]  sel;
		logic [11:0] tcol;
		logic [11:0] trow;
		logic        last;
	} texel_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;

	twcs_req_if req ();
	twcs_pix_if pix ();

	textured_wall_column_span dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req.sink), .pix(pix.source)
	);

	always #5 clk = ~clk;

	// Stimulus and expectation stores
	ray_item_t ray_queue[$];
	texel_t    texel_expect[$];
	int        errors, n_starts, n_pixels, items_made;
	int        cycles;
	bit        calm;

	// Shadow of configuration and span state
	logic [11:0] cfg_h;
	logic [23:0] tex_cfg[4];
	logic        span_on;
	logic [10:0] cur_row, end_r;
	logic [27:0] tpos, tstep;
	logic [11:0] hold_tcol, hold_col;
	logic [1:0]  hold_side;

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 14);
	endfunction

	// Column setup or pixel emission for one accepted transaction
	task automatic wall_predict(ray_item_t it);
		longint unsigned h, linh, first, last_row, wallx, w, th, col, prod, trow;
		longint signed rv;
		logic xy;
		texel_t t;
		if (it.kind == KIND_START) begin
			n_starts++;
			h = cfg_h;
			if (h > MAX_SCREEN_HEIGHT) h = MAX_SCREEN_HEIGHT;
			span_on = 1'b0;
			hold_col = it.column;
			hold_side = it.side;
			linh = (it.wdist == 0) ? h : (h << FRAC_BITS) / it.wdist;
			first = (linh / 2 > h / 2) ? 0 : h / 2 - linh / 2;
			last_row = h / 2 + linh / 2;
			if (h == 0) last_row = 0;
			else if (last_row >= h) last_row = h - 1;
			xy = (it.side == SIDE_SOUTH) || (it.side == SIDE_NORTH);
			rv = xy ? it.ry : it.rx;
			prod = longint'(it.wdist) * rv;
			wallx = ((xy ? it.py : it.px) + (prod >> FRAC_BITS)) & 64'hFFFF;
			w = tex_cfg[it.side][11:0];
			th = tex_cfg[it.side][23:12];
			if (w == 0) begin
				col = 0;
			end else begin
				col = (wallx * w) >> FRAC_BITS;
				// mirrored faces
				if ((xy && it.rx > 0) || (it.side == SIDE_EAST && it.ry < 0))
					col = w - col - 1;
			end
			hold_tcol = col[11:0];
			tstep = (linh == 0) ? 28'd0 : 28'((th << FRAC_BITS) / linh);
			tpos = 28'((first + linh / 2 - h / 2) * tstep);
			cur_row = first[10:0];
			end_r = last_row[10:0];
			span_on = (h != 0) && (linh != 0) && (last_row > first);
		end else if (span_on) begin
			th = tex_cfg[hold_side][23:12];
			trow = tpos >> FRAC_BITS;
			if (th == 0) trow = 0;
			else if (trow > th - 1) trow = th - 1;
			t.column = hold_col;
			t.row = cur_row;
			t.sel = hold_side;
			t.tcol = hold_tcol;
			t.trow = trow[11:0];
			t.last = ({1'b0, cur_row} + 12'd1 >= {1'b0, end_r});
			texel_expect.push_back(t);
			tpos = tpos + tstep;
			cur_row = cur_row + 11'd1;
			if (t.last) span_on = 1'b0;
		end
	endtask

	// Driver: presents queued transactions with random gaps
	int gap_cnt;
	always @(posedge clk or negedge arst_n) begin
		ray_item_t it;
		if (!arst_n) begin
			req.valid <= 1'b0;
			gap_cnt <= 0;
		end else if (!req.valid || req.ready) begin
			if (gap_cnt != 0) begin
				req.valid <= 1'b0;
				gap_cnt <= gap_cnt - 1;
			end else if (ray_queue.size() != 0) begin
				it = ray_queue.pop_front();
				req.valid <= 1'b1;
				req.kind <= it.kind;
				req.column <= it.column;
				req.wall_dist <= it.wdist;
				req.hit_side <= it.side;
				req.pos_x <= it.px;
				req.pos_y <= it.py;
				req.ray_x <= it.rx;
				req.ray_y <= it.ry;
				if ($urandom_range(0, 40) == 0) calm = ~calm;
				gap_cnt <= draw_wait();
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Sink stall control
	int stall_cnt;
	always @(posedge clk or negedge arst_n) begin
		int s;
		if (!arst_n) begin
			pix.ready <= 1'b1;
			stall_cnt <= 0;
		end else if (pix.valid && pix.ready) begin
			s = draw_wait();
			if (s != 0) begin
				pix.ready <= 1'b0;
				stall_cnt <= s;
			end
		end else if (!pix.ready) begin
			if (stall_cnt <= 1) pix.ready <= 1'b1;
			stall_cnt <= stall_cnt - 1;
		end
	end

	// Monitor: predict on request transactions, check pixel transactions
	always @(posedge clk) begin
		ray_item_t it;
		texel_t e;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				it.kind = req.kind;
				it.column = req.column;
				it.wdist = req.wall_dist;
				it.side = req.hit_side;
				it.px = req.pos_x;
				it.py = req.pos_y;
				it.rx = req.ray_x;
				it.ry = req.ray_y;
				wall_predict(it);
			end
			if (pix.valid && pix.ready) begin
				n_pixels++;
				if (texel_expect.size() == 0) begin
					$error("unexpected pixel row %0d col %0d", pix.out_row, pix.out_column);
					errors++;
				end else begin
					e = texel_expect.pop_front();
					if (pix.out_column !== e.column) begin
						$error("out_column exp %0d got %0d", e.column, pix.out_column);
						errors++;
					end
					if (pix.out_row !== e.row) begin
						$error("out_row exp %0d got %0d", e.row, pix.out_row);
						errors++;
					end
					if (pix.texture_select !== e.sel) begin
						$error("texture_select exp %0d got %0d", e.sel, pix.texture_select);
						errors++;
					end
					if (pix.texel_col !== e.tcol) begin
						$error("texel_col exp %0d got %0d", e.tcol, pix.texel_col);
						errors++;
					end
					if (pix.texel_row !== e.trow) begin
						$error("texel_row exp %0d got %0d", e.trow, pix.texel_row);
						errors++;
					end
					if (pix.last !== e.last) begin
						$error("last exp %0d got %0d", e.last, pix.last);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic ray_item_t rand_ray(logic kind);
		ray_item_t it;
		it.kind = kind;
		it.column = $urandom;
		it.wdist = $urandom;
		it.side = $urandom;
		it.px = $urandom;
		it.py = $urandom;
		it.rx = $urandom;
		it.ry = $urandom;
		case ($urandom_range(0, 7))
			0: it.rx = -18'sd131072;
			1: it.rx = 18'sd131071;
			2: it.ry = -18'sd131072;
			3: it.ry = 18'sd131071;
			default: ;
		endcase
		return it;
	endfunction

	task automatic push_ray(ray_item_t it);
		ray_queue.push_back(it);
		items_made++;
	endtask

	task automatic push_ticks(int n);
		for (int i = 0; i < n; i++) push_ray(rand_ray(KIND_TICK));
	endtask

	// Start with a distance that yields about rows lines of wall
	task automatic push_column(int rows, logic [1:0] side);
		ray_item_t it;
		int h;
		it = rand_ray(KIND_START);
		it.side = side;
		h = (cfg_h > MAX_SCREEN_HEIGHT) ? MAX_SCREEN_HEIGHT : cfg_h;
		if (h != 0) it.wdist = 26'((h << FRAC_BITS) / rows);
		push_ray(it);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == REG_SCREEN_HEIGHT) cfg_h = data[11:0];
		else if (idx <= REG_TEX_WEST) tex_cfg[idx - 1] = data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (ray_queue.size() != 0 || req.valid || texel_expect.size() != 0)
			@(posedge clk);
		repeat (SETUP_DRAIN) @(posedge clk);
	endtask

	task automatic configure(int phase);
		logic [23:0] tex[4];
		logic [11:0] h;
		case (phase)
			1: begin h = 12'hFFF; tex = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}; end
			2: begin h = 12'd0; tex = '{24'h040040, 24'h040040, 24'h040040, 24'h040040}; end
			3: begin h = 12'd1; tex = '{24'h001001, 24'h010020, 24'h002008, 24'h008004}; end
			// zero width and zero height textures
			4: begin h = 12'd16; tex = '{24'h000040, 24'h040000, 24'h000000, 24'h3FF7FF}; end
			default: begin
				h = $urandom_range(1, 300);
				for (int i = 0; i < 4; i++) tex[i] = {12'($urandom_range(0, 300)),
					12'($urandom_range(0, 300))};
			end
		endcase
		write_reg(REG_SCREEN_HEIGHT, h);
		write_reg(REG_TEX_SOUTH, tex[0]);
		write_reg(REG_TEX_EAST, tex[1]);
		write_reg(REG_TEX_NORTH, tex[2]);
		write_reg(REG_TEX_WEST, tex[3]);
		// out-of-range index must be ignored
		write_reg(3'($urandom_range(5, 7)), $urandom);
	endtask

	initial begin
		ray_item_t it;
		int rows;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.kind = KIND_TICK;
		req.column = '0;
		req.wall_dist = '0;
		req.hit_side = '0;
		req.pos_x = '0;
		req.pos_y = '0;
		req.ray_x = '0;
		req.ray_y = '0;
		pix.ready = 1'b1;
		calm = 1'b0;
		cfg_h = 12'd480;
		for (int i = 0; i < 4; i++) tex_cfg[i] = 24'h040040;
		span_on = 1'b0;
		cur_row = '0;
		end_r = '0;
		tpos = '0;
		tstep = '0;
		hold_tcol = '0;
		hold_col = '0;
		hold_side = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: tick with no span, every side with rays mirrored on all but west, extremes
		push_ticks(1);
		for (int s = 0; s < 4; s++) begin
			it = rand_ray(KIND_START);
			it.side = s;
			it.wdist = 26'((480 << FRAC_BITS) / 4);
			it.px = '1;
			it.py = '1;
			it.rx = (s % 2) ? -18'sd131072 : 18'sd131071;
			it.ry = (s % 2) ? -18'sd131072 : 18'sd131071;
			push_ray(it);
			push_ticks(3);
		end
		it = rand_ray(KIND_START);
		it.wdist = '1;
		push_ray(it);
		push_ticks(1);
		// restart mid-span drops the old span
		push_column(6, SIDE_WEST);
		push_ticks(2);
		push_column(3, SIDE_SOUTH);
		push_ticks(4);

		// Phases of settings, each with random columns
		for (int phase = 1; items_made < ITEM_GOAL; phase++) begin
			wait_idle();
			configure(phase);
			for (int n = 0; n < 240 && items_made < ITEM_GOAL; n = n) begin
				case ($urandom_range(0, 19))
					0: begin push_ray(rand_ray(KIND_START)); push_ticks(2); n += 3; end
					1: begin
						if (cfg_h <= 64) begin
							it = rand_ray(KIND_START);
							it.wdist = '0;
							push_ray(it);
							push_ticks(cfg_h);
							n += cfg_h + 1;
						end
					end
					2: begin push_ticks(1); n++; end
					default: begin
						rows = $urandom_range(1, 40);
						push_column(rows, $urandom);
						// mostly complete spans, sometimes cut short or overrun
						rows = ($urandom_range(0, 5) == 0) ? $urandom_range(0, rows + 3) : rows;
						push_ticks(rows);
						n += rows + 1;
					end
				endcase
			end
		end

		while (ray_queue.size() != 0 || req.valid || texel_expect.size() != 0)
			@(posedge clk);
		repeat (SETUP_DRAIN) @(posedge clk);
		$display("covered %0d column starts and %0d wall pixels over %0d transactions",
			n_starts, n_pixels, items_made);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/twcs_pkg.sv
rtl/twcs_req_if.sv
rtl/twcs_pix_if.sv
rtl/twcs_ctrl.sv
rtl/twcs_dp.sv
rtl/textured_wall_column_span.sv
rtl/twcs_chk.sv
test/textured_wall_column_span_tb.sv
